// ===== sv/ifr_pkg.sv =====
// Shared types, constants and the CRC byte step for the IMU frame receiver.
package ifr_pkg;

  localparam int unsigned WORD_COUNT = 19;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned RAM_AW     = IDX_W + 1;
  localparam int unsigned CNT_W      = 10;

  localparam logic [CNT_W-1:0] COUNT_SAT        = 10'd1023;
  localparam logic [15:0]      DATA_PAYLOAD_MIN = 16'd76;
  localparam logic [15:0]      CRC_POLY         = 16'h1021;
  localparam logic [7:0]       HDR_BYTE0        = 8'h5A;
  localparam logic [7:0]       HDR_BYTE1        = 8'hA5;
  localparam logic [7:0]       TYPE_DATA        = 8'h91;
  localparam logic [7:0]       TYPE_OTHER       = 8'h92;

  typedef enum logic [2:0] {
    ST_DATA_OK  = 3'd0,
    ST_OTHER_OK = 3'd1,
    ST_BAD_HDR  = 3'd2,
    ST_BAD_CRC  = 3'd3,
    ST_BAD_LEN  = 3'd4,
    ST_BAD_TYPE = 3'd5
  } status_t;

  // frame-end event, parser to emitter
  typedef struct packed {
    logic    start;
    status_t status;
    logic    bank;
  } frame_evt_t;

  // word store write port
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [31:0]       data;
  } ram_wr_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/ifr_stream_if.sv =====
// Byte input and result output channel interfaces.
interface ifr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface ifr_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  word_index;
  logic [31:0] word_value;
  logic        last;

  modport source (output valid, output status, output word_index, output word_value,
                  output last, input ready);
  modport sink (input valid, input status, input word_index, input word_value,
                input last, output ready);
endinterface

// ===== sv/imu_frame_receiver_crc16.sv =====
// Top level of the IMU frame receiver with CRC-16 check.
// Input channel in_ch: one frame byte per beat, frame_end high on the last byte
// before line idle. Result channel out_ch: one status beat per frame; a good
// type-0x91 frame gives a run of 19 beats (status 0, tag at index 0, then the
// 18 raw words), last set on the final beat. Every other outcome is one beat
// with index 0, value 0 and last set.
// Throughput: one byte per cycle while no frame_end byte is held off. The word
// store is two banks in one synchronous RAM; a frame fills one bank while the
// previous run drains the other, so payload bytes keep flowing during a run.
// The first result beat shows in the cycle after the frame_end beat; the run's
// beats then follow on while the receiver does not stall.
// A frame_end beat is held off (ready low) while a result beat is showing,
// unless that beat is the final one of its frame and out_ch takes it in the
// same cycle, so one-beat frames can follow each other with no gap and
// results never overtake one another. When out_ch stalls, the shown beat
// holds and the run pauses; bytes that are not frame_end still go in.
// Reset clears the frame state and the output stage; the store needs none.
module imu_frame_receiver_crc16 #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic          clk,
  input  logic          rst_n,
  ifr_byte_if.sink      in_ch,
  ifr_result_if.source  out_ch
);

  ifr_pkg::ram_wr_t          wr;
  ifr_pkg::frame_evt_t       evt;
  logic [ifr_pkg::RAM_AW-1:0] rd_addr;
  logic [31:0]               rd_data;
  logic                      busy;
  logic                      in_fire;
  logic                      out_fire;

  // frame_end waits until the output stage frees up at this edge
  assign in_ch.ready = !busy || !in_ch.frame_end || (out_ch.ready && out_ch.last);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  ifr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .data_byte (in_ch.data_byte),
    .frame_end (in_ch.frame_end),
    .wr        (wr),
    .evt       (evt)
  );

  ifr_word_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ifr_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .evt            (evt),
    .rd_data        (rd_data),
    .rd_addr        (rd_addr),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_status     (out_ch.status),
    .out_word_index (out_ch.word_index),
    .out_word_value (out_ch.word_value),
    .out_last       (out_ch.last),
    .busy           (busy)
  );

  // a frame only ends with the output stage empty or its final beat leaving
  a_end_needs_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.frame_end) |-> (!out_ch.valid || (out_ch.ready && out_ch.last)))
    else $error("frame end accepted while a result beat is still pending");

  // a run closes exactly on its last word
  a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last && out_ch.status == ifr_pkg::ST_DATA_OK) |->
    (out_ch.word_index == 5'(ifr_pkg::WORD_COUNT - 1)))
    else $error("run ended on the wrong word");

  // run beats follow one another with rising index
  a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_ch.last && out_ch.status == ifr_pkg::ST_DATA_OK) |=>
    (out_ch.valid && out_ch.word_index == $past(out_ch.word_index) + 5'd1))
    else $error("run index did not advance by one");

  // status-only beats carry no word
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ifr_pkg::ST_DATA_OK) |->
    (out_ch.last && out_ch.word_index == 5'd0 && out_ch.word_value == 32'd0))
    else $error("status beat carries word data");

endmodule

// ===== sv/ifr_word_ram.sv =====
// Two-bank word store: one write port, one registered read port.
module ifr_word_ram (
  input  logic                      clk,
  input  ifr_pkg::ram_wr_t          wr,
  input  logic [ifr_pkg::RAM_AW-1:0] rd_addr,
  output logic [31:0]               rd_data
);

  localparam int unsigned DEPTH = 2 ** ifr_pkg::RAM_AW;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/ifr_parser.sv =====
// Byte parser: header, length, CRC, word assembly and frame-end status.
module ifr_parser #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                frame_end,
  output ifr_pkg::ram_wr_t    wr,
  output ifr_pkg::frame_evt_t evt
);

  localparam int unsigned CW = ifr_pkg::CNT_W;

  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]   payload_length_r, payload_length_nxt;
  logic [15:0]   received_crc_r, received_crc_nxt;
  logic [15:0]   running_crc_r, running_crc_nxt;
  logic          header_good_r, header_good_nxt;
  logic [7:0]    frame_type_r, frame_type_nxt;
  logic          wr_bank_r, wr_bank_nxt;
  logic [23:0]   asm_r, asm_nxt;

  logic [CW-1:0] idx;
  logic [CW-1:0] p;
  logic          in_pay;
  logic [16:0]   want_total;
  ifr_pkg::status_t st;

  assign idx = byte_count_r;
  assign p   = idx - CW'(6);
  assign in_pay = (idx >= CW'(6)) && ({6'd0, p} < payload_length_r);

  always_comb begin
    byte_count_nxt     = byte_count_r;
    payload_length_nxt = payload_length_r;
    received_crc_nxt   = received_crc_r;
    running_crc_nxt    = running_crc_r;
    header_good_nxt    = header_good_r;
    frame_type_nxt     = frame_type_r;
    wr_bank_nxt        = wr_bank_r;
    asm_nxt            = asm_r;
    wr                 = '0;
    evt                = '0;
    st                 = ifr_pkg::ST_BAD_TYPE;
    want_total         = '0;

    if (fire && idx != ifr_pkg::COUNT_SAT) begin
      byte_count_nxt = idx + CW'(1);
      if (idx == CW'(0) && data_byte != ifr_pkg::HDR_BYTE0) header_good_nxt = 1'b0;
      if (idx == CW'(1) && data_byte != ifr_pkg::HDR_BYTE1) header_good_nxt = 1'b0;
      if (idx == CW'(2)) payload_length_nxt = {payload_length_r[15:8], data_byte};
      if (idx == CW'(3)) payload_length_nxt = {data_byte, payload_length_r[7:0]};
      if (idx == CW'(4)) received_crc_nxt = {received_crc_r[15:8], data_byte};
      if (idx == CW'(5)) received_crc_nxt = {data_byte, received_crc_r[7:0]};
      if (idx < CW'(4)) begin
        running_crc_nxt = ifr_pkg::crc16_byte(running_crc_r, data_byte);
      end else if (in_pay) begin
        running_crc_nxt = ifr_pkg::crc16_byte(running_crc_r, data_byte);
        if (p == CW'(0)) frame_type_nxt = data_byte;
        if (p == CW'(1)) begin
          wr.we   = 1'b1;
          wr.addr = {wr_bank_r, ifr_pkg::IDX_W'(0)};
          wr.data = {24'd0, data_byte};
        end
        if (p >= CW'(4) && p < CW'(ifr_pkg::DATA_PAYLOAD_MIN)) begin
          asm_nxt = {data_byte, asm_r[23:8]};
          // fourth byte of a word: write the whole little-endian word
          if (p[1:0] == 2'b11) begin
            wr.we   = 1'b1;
            wr.addr = {wr_bank_r, p[ifr_pkg::IDX_W+1:2]};
            wr.data = {data_byte, asm_r};
          end
        end
      end
    end

    if (fire && frame_end) begin
      want_total = {1'b0, payload_length_nxt} + 17'd6;
      if (!header_good_nxt || byte_count_nxt < CW'(2)) begin
        st = ifr_pkg::ST_BAD_HDR;
      end else if (byte_count_nxt == ifr_pkg::COUNT_SAT || byte_count_nxt < CW'(6) ||
                   payload_length_nxt > 16'(MAX_PAYLOAD) ||
                   {7'd0, byte_count_nxt} != want_total) begin
        st = ifr_pkg::ST_BAD_LEN;
      end else if (running_crc_nxt != received_crc_nxt) begin
        st = ifr_pkg::ST_BAD_CRC;
      end else if (frame_type_nxt == ifr_pkg::TYPE_DATA &&
                   payload_length_nxt < ifr_pkg::DATA_PAYLOAD_MIN) begin
        st = ifr_pkg::ST_BAD_LEN;
      end else if (frame_type_nxt == ifr_pkg::TYPE_DATA) begin
        st = ifr_pkg::ST_DATA_OK;
      end else if (frame_type_nxt == ifr_pkg::TYPE_OTHER) begin
        st = ifr_pkg::ST_OTHER_OK;
      end else begin
        st = ifr_pkg::ST_BAD_TYPE;
      end
      evt.start  = 1'b1;
      evt.status = st;
      evt.bank   = wr_bank_r;
      // the finished bank goes to the emitter; after a good data frame the next frame fills the other one
      if (st == ifr_pkg::ST_DATA_OK) wr_bank_nxt = ~wr_bank_r;
      byte_count_nxt     = '0;
      payload_length_nxt = '0;
      received_crc_nxt   = '0;
      running_crc_nxt    = '0;
      header_good_nxt    = 1'b1;
      frame_type_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= '0;
      payload_length_r <= '0;
      received_crc_r   <= '0;
      running_crc_r    <= '0;
      header_good_r    <= 1'b1;
      frame_type_r     <= '0;
      wr_bank_r        <= 1'b0;
    end else begin
      byte_count_r     <= byte_count_nxt;
      payload_length_r <= payload_length_nxt;
      received_crc_r   <= received_crc_nxt;
      running_crc_r    <= running_crc_nxt;
      header_good_r    <= header_good_nxt;
      frame_type_r     <= frame_type_nxt;
      wr_bank_r        <= wr_bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
  end

endmodule

// ===== sv/ifr_emitter.sv =====
// Result sequencer: single status beats and the 19-word run read from the store.
module ifr_emitter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ifr_pkg::frame_evt_t        evt,
  input  logic [31:0]                rd_data,
  output logic [ifr_pkg::RAM_AW-1:0] rd_addr,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [4:0]                 out_word_index,
  output logic [31:0]                out_word_value,
  output logic                       out_last,
  output logic                       busy
);

  localparam int unsigned IW = ifr_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ifr_pkg::WORD_COUNT - 1);

  logic             valid_r, valid_nxt;
  logic             run_r, run_nxt;
  logic             last_r, last_nxt;
  logic             bank_r, bank_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  ifr_pkg::status_t status_r, status_nxt;
  logic             load;

  assign load = !valid_r || out_ready;

  always_comb begin
    valid_nxt  = valid_r;
    run_nxt    = run_r;
    last_nxt   = last_r;
    bank_nxt   = bank_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    if (load) begin
      if (valid_r && run_r && !last_r) begin
        idx_nxt  = idx_r + IW'(1);
        last_nxt = (idx_nxt == LAST_IDX);
      end else if (evt.start) begin
        valid_nxt  = 1'b1;
        status_nxt = evt.status;
        run_nxt    = (evt.status == ifr_pkg::ST_DATA_OK);
        last_nxt   = !run_nxt;
        bank_nxt   = evt.bank;
        idx_nxt    = '0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
    // re-reading the shown entry while stalled keeps the read data steady
    rd_addr = {bank_nxt, idx_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      run_r   <= 1'b0;
      last_r  <= 1'b0;
      bank_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      run_r   <= run_nxt;
      last_r  <= last_nxt;
      bank_r  <= bank_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_word_index = idx_r;
  assign out_word_value = run_r ? rd_data : 32'd0;
  assign out_last       = last_r;
  assign busy           = valid_r;

endmodule

// ===== verif/imu_frame_receiver_crc16_tb.sv =====
// Self-checking testbench for the IMU frame receiver: directed frames with random payloads.
module imu_frame_receiver_crc16_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ifr_pkg::*;

  localparam int unsigned MAX_LEN = 512;

  // one expected result beat
  typedef struct {
    status_t     status;
    logic [4:0]  word_idx;
    logic [31:0] value;
    logic        last;
  } result_beat_t;

  logic clk;
  logic rst_n;
  bit   calm;       // suppresses idling on both sides

  ifr_byte_if   in_ch ();
  ifr_result_if out_ch ();

  imu_frame_receiver_crc16 #(
    .MAX_PAYLOAD(MAX_LEN)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predicted frame state, mirroring what the receiver should hold.
  logic [CNT_W-1:0] seen_bytes;
  logic [15:0]      len_field_m;
  logic [15:0]      crc_field_m;
  logic [15:0]      crc_run_m;
  logic             hdr_ok_m;
  logic [7:0]       type_m;
  logic [31:0]      words_m [WORD_COUNT];

  result_beat_t pending_results [$];
  logic [7:0]   payload_buf [$];
  logic [7:0]   frame_buf [$];

  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned results_predicted;
  int unsigned beats_checked;
  int unsigned mismatches;
  int unsigned status_seen [6];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // CRC-16/XMODEM, fed one data bit at a time
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic clear_frame_model();
    seen_bytes  = '0;
    len_field_m = '0;
    crc_field_m = '0;
    crc_run_m   = '0;
    hdr_ok_m    = 1'b1;
    type_m      = '0;
  endtask

  task automatic expect_beat(input status_t st, input logic [4:0] idx,
                             input logic [31:0] val, input logic lst);
    result_beat_t r;
    r.status   = st;
    r.word_idx = idx;
    r.value    = val;
    r.last     = lst;
    pending_results.push_back(r);
    results_predicted++;
  endtask

  // Folds one accepted byte into the predicted frame; at frame end queues the
  // expected status beat or the 19-beat word run.
  task automatic track_frame_byte(input logic [7:0] b, input logic fe);
    int unsigned pos;
    int unsigned p;
    int unsigned w;
    int unsigned sh;
    int unsigned total;
    int unsigned plen;
    status_t     st;
    pos = seen_bytes;
    if (pos < COUNT_SAT) begin
      seen_bytes = seen_bytes + 1'b1;
      if (pos == 0 && b != HDR_BYTE0) hdr_ok_m = 1'b0;
      if (pos == 1 && b != HDR_BYTE1) hdr_ok_m = 1'b0;
      if (pos == 2) len_field_m[7:0]  = b;
      if (pos == 3) len_field_m[15:8] = b;
      if (pos == 4) crc_field_m[7:0]  = b;
      if (pos == 5) crc_field_m[15:8] = b;
      if (pos < 4) begin
        crc_run_m = crc_feed(crc_run_m, b);
      end else if (pos >= 6 && pos - 6 < len_field_m) begin
        p = pos - 6;
        crc_run_m = crc_feed(crc_run_m, b);
        if (p == 0) type_m = b;
        if (p == 1) words_m[0] = {24'h0, b};
        // payload bytes 4..75 build words 1..18, little-endian
        if (p >= 4 && p < DATA_PAYLOAD_MIN) begin
          w  = (p - 4) / 4 + 1;
          sh = ((p - 4) % 4) * 8;
          words_m[w][sh +: 8] = b;
        end
      end
    end
    if (fe) begin
      total = seen_bytes;
      plen  = len_field_m;
      // first failing check wins
      if (!hdr_ok_m || total < 2) begin
        st = ST_BAD_HDR;
      end else if (total >= COUNT_SAT || total < 6 || plen > MAX_LEN || total != 6 + plen) begin
        st = ST_BAD_LEN;
      end else if (crc_run_m != crc_field_m) begin
        st = ST_BAD_CRC;
      end else if (type_m == TYPE_DATA && len_field_m < DATA_PAYLOAD_MIN) begin
        st = ST_BAD_LEN;
      end else if (type_m == TYPE_DATA) begin
        st = ST_DATA_OK;
      end else if (type_m == TYPE_OTHER) begin
        st = ST_OTHER_OK;
      end else begin
        st = ST_BAD_TYPE;
      end
      status_seen[st]++;
      if (st == ST_DATA_OK) begin
        for (int k = 0; k < WORD_COUNT; k++) begin
          expect_beat(ST_DATA_OK, k[4:0], words_m[k], k == WORD_COUNT - 1);
        end
      end else begin
        expect_beat(st, 5'd0, 32'd0, 1'b1);
      end
      frames_sent++;
      clear_frame_model();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every accepted beat against the oldest expectation
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input result_beat_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected st=%0d idx=%0d val=%h last=%b,",
               $realtime, what, want.status, want.word_idx, want.value, want.last);
      $display("    got st=%0d idx=%0d val=%h last=%b",
               out_ch.status, out_ch.word_index, out_ch.word_value, out_ch.last);
    end
  endtask

  always @(posedge clk) begin
    result_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        want.status   = ST_DATA_OK;
        want.word_idx = '0;
        want.value    = '0;
        want.last     = 1'b0;
        report_mismatch("unexpected beat (nothing pending)", want);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status || out_ch.word_index !== want.word_idx ||
            out_ch.word_value !== want.value || out_ch.last !== want.last) begin
          report_mismatch("result mismatch", want);
        end
      end
    end
  end

  // Receiver back-pressure: ready drops with a chance of about 22 percent, unless calm.
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 22);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  // Sends one byte beat. Entered just after a falling edge; returns just after
  // the falling edge that follows acceptance, leaving valid high so the next
  // beat can follow without a bubble.
  task automatic send_byte(input logic [7:0] b, input logic fe);
    while (!calm && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.frame_end <= fe;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_frame_byte(b, fe);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  // Line idle until every predicted beat has been seen.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Payload: type byte then n-1 bytes, random or a fixed pad value.
  task automatic fill_payload(input logic [7:0] kind, input int unsigned n,
                              input bit padded = 1'b0, input logic [7:0] pad = 8'h00);
    payload_buf = {};
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) begin
        payload_buf.push_back(kind);
      end else begin
        payload_buf.push_back(padded ? pad : rand_byte());
      end
    end
  endtask

  // Frames payload_buf with header, the given length field and a CRC that is
  // right or deliberately wrong.
  task automatic wrap_payload(input logic [15:0] lf, input bit crc_good = 1'b1);
    logic [15:0] c;
    logic [7:0]  spoil;
    c = crc_feed(16'h0000, HDR_BYTE0);
    c = crc_feed(c, HDR_BYTE1);
    c = crc_feed(c, lf[7:0]);
    c = crc_feed(c, lf[15:8]);
    foreach (payload_buf[i]) begin
      if (i < lf) c = crc_feed(c, payload_buf[i]);
    end
    if (!crc_good) begin
      spoil = rand_byte();
      c[7:0] = c[7:0] ^ (spoil | 8'h01);
    end
    frame_buf = {};
    frame_buf.push_back(HDR_BYTE0);
    frame_buf.push_back(HDR_BYTE1);
    frame_buf.push_back(lf[7:0]);
    frame_buf.push_back(lf[15:8]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
    foreach (payload_buf[i]) frame_buf.push_back(payload_buf[i]);
  endtask

  task automatic good_frame(input logic [7:0] kind, input int unsigned n);
    fill_payload(kind, n);
    wrap_payload(n[15:0]);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_header_errors();
    // lone bytes: too short for a header, one of them a wrong first byte
    frame_buf = {HDR_BYTE0};
    send_frame();
    frame_buf = {8'h00};
    send_frame();
    // header alone: good header but no room for length and CRC
    frame_buf = {HDR_BYTE0, HDR_BYTE1};
    send_frame();
    // otherwise good frame with a spoilt second header byte
    good_frame(TYPE_OTHER, 1);
    frame_buf[1] = 8'h5A;
    send_frame();
    wait_drained();
  endtask

  task automatic test_length_errors();
    good_frame(TYPE_OTHER, 2);
    void'(frame_buf.pop_back());     // one byte short
    send_frame();
    good_frame(TYPE_OTHER, 1);
    frame_buf.push_back(rand_byte()); // one byte over
    send_frame();
    fill_payload(TYPE_OTHER, 1);
    wrap_payload(16'hFFFF);           // length field at its top
    send_frame();
    good_frame(TYPE_DATA, 2);         // data frame far too short for the words
    send_frame();
    wait_drained();
  endtask

  task automatic test_crc_and_type();
    fill_payload(TYPE_OTHER, 2);
    wrap_payload(16'd2, 1'b0);
    send_frame();
    good_frame(8'h00, 0);             // empty payload: type reads as zero
    send_frame();
    good_frame(8'hFF, 1);
    send_frame();
    wait_drained();
  endtask

  task automatic test_data_runs();
    // no idling on either side for the whole data frame
    calm = 1'b1;
    good_frame(TYPE_DATA, 78);        // two spare bytes past the last word
    send_frame();
    calm = 1'b0;
    // short frames right behind: their ends wait for the run to drain, and
    // the tag write lands in the other bank while the run is read
    good_frame(TYPE_OTHER, 2);
    send_frame();
    frame_buf = {8'h00};
    send_frame();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    calm            = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.frame_end = 1'b0;
    out_ch.ready    = 1'b0;
    clear_frame_model();
    for (int k = 0; k < WORD_COUNT; k++) words_m[k] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_header_errors();
    test_length_errors();
    test_crc_and_type();
    test_data_runs();

    // quiet tail: nothing more may come out
    in_ch.valid <= 1'b0;
    repeat (40) @(negedge clk);

    $display("Ran %0d frames over %0d bytes; %0d result beats checked, %0d word runs.",
             frames_sent, bytes_sent, beats_checked, status_seen[ST_DATA_OK]);
    $display("Other ok %0d, bad hdr %0d, bad crc %0d, bad len %0d, bad type %0d; errors %0d.",
             status_seen[ST_OTHER_OK], status_seen[ST_BAD_HDR], status_seen[ST_BAD_CRC],
             status_seen[ST_BAD_LEN], status_seen[ST_BAD_TYPE], mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
